[rtl/e2r_pkg.sv]
// Package for the Euler-angle to rotation-matrix block: CORDIC constants and types.
package e2r_pkg;

  localparam int unsigned Iters = 30;
  localparam int unsigned WorkFrac = 30;
  localparam int unsigned WorkBits = 34;
  localparam int unsigned PhaseBits = 34;
  localparam logic signed [WorkBits-1:0] CordicK = 34'sd652032874;

  typedef logic signed [WorkBits-1:0] work_t;
  typedef logic signed [PhaseBits-1:0] phase_t;

  typedef struct packed {
    work_t sx;
    work_t cx;
    work_t sy;
    work_t cy;
    work_t sz;
    work_t cz;
  } trig_t;

  function automatic phase_t atan_turn(input int unsigned i);
    logic [31:0] v;
    begin
      case (i)
        0: v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
        3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
        6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
        9: v = 32'h00145F2F;  10: v = 32'h000A2F98; 11: v = 32'h000517CC;
        12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
        15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
        18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
        21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
        24: v = 32'h00000029; 25: v = 32'h00000014; 26: v = 32'h0000000A;
        27: v = 32'h00000005; 28: v = 32'h00000003; 29: v = 32'h00000001;
        default: v = 32'h0;
      endcase
      atan_turn = phase_t'({2'b00, v});
    end
  endfunction

  // Q30 multiply, rounded half up.
  function automatic work_t mulq(input work_t a, input work_t b);
    logic signed [2*WorkBits-1:0] p;
    begin
      p = a * b + (68'sd1 <<< (WorkFrac - 1));
      mulq = work_t'(p >>> WorkFrac);
    end
  endfunction

endpackage

[rtl/e2r_cordic.sv]
// Pipelined rotation-mode CORDIC, one stage per iteration, sine and cosine of one angle.
module e2r_cordic import e2r_pkg::*; #(
  parameter int unsigned AngleBits = 16
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [AngleBits-1:0] angle_i,
  output work_t                sin_o,
  output work_t                cos_o
);

  work_t       x_q [Iters+1];
  work_t       y_q [Iters+1];
  phase_t      d_q [Iters+1];
  logic [1:0]  quad_q [Iters+1];

  logic [31:0] p;
  logic [31:0] t;
  logic [31:0] r;

  always_comb begin
    p = {angle_i, {(32-AngleBits){1'b0}}};
    t = p + 32'h20000000;
    r = p - {t[31:30], 30'b0};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= CordicK;
      y_q[0] <= '0;
      d_q[0] <= phase_t'($signed(r));
      quad_q[0] <= t[31:30];
    end
  end

  for (genvar i = 0; i < Iters; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quad_q[i+1] <= quad_q[i];
        if (!d_q[i][PhaseBits-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          d_q[i+1] <= d_q[i] - atan_turn(i);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          d_q[i+1] <= d_q[i] + atan_turn(i);
        end
      end
    end
  end

  always_comb begin
    case (quad_q[Iters])
      2'd0: begin cos_o = x_q[Iters];  sin_o = y_q[Iters];  end
      2'd1: begin cos_o = -y_q[Iters]; sin_o = x_q[Iters];  end
      2'd2: begin cos_o = -x_q[Iters]; sin_o = -y_q[Iters]; end
      default: begin cos_o = y_q[Iters]; sin_o = -x_q[Iters]; end
    endcase
  end

endmodule

[rtl/e2r_front.sv]
// Front end: three CORDIC pipelines turning an angle triple into sines and cosines.
module e2r_front import e2r_pkg::*; #(
  parameter int unsigned AngleBits = 16,
  parameter int unsigned Depth = 31
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 in_valid_i,
  input  logic [AngleBits-1:0] ax_i,
  input  logic [AngleBits-1:0] ay_i,
  input  logic [AngleBits-1:0] az_i,
  output logic                 out_valid_o,
  output trig_t                trig_o
);

  logic [Depth-1:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[Depth-2:0], in_valid_i};
    end
  end

  assign out_valid_o = v_q[Depth-1];

  e2r_cordic #(.AngleBits(AngleBits)) u_cx (
    .clk_i, .en_i, .angle_i(ax_i), .sin_o(trig_o.sx), .cos_o(trig_o.cx));
  e2r_cordic #(.AngleBits(AngleBits)) u_cy (
    .clk_i, .en_i, .angle_i(ay_i), .sin_o(trig_o.sy), .cos_o(trig_o.cy));
  e2r_cordic #(.AngleBits(AngleBits)) u_cz (
    .clk_i, .en_i, .angle_i(az_i), .sin_o(trig_o.sz), .cos_o(trig_o.cz));

endmodule

[rtl/e2r_fifo.sv]
// Short queue of sine/cosine sets between the front and back parts.
module e2r_fifo import e2r_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  trig_t data_i,
  input  logic  pop_i,
  output trig_t data_o,
  output logic  empty_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  trig_t         mem_q [Depth];
  logic [Aw-1:0] wr_q;
  logic [Aw-1:0] rd_q;
  logic [$clog2(Depth+1)-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == Aw'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == Aw'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (push_i ? 1'b1 : 1'b0) - (pop_i ? 1'b1 : 1'b0);
    end
  end

  assign data_o = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

endmodule

[rtl/e2r_back.sv]
// Back end: matrix products, rounding to the output format and saturation.
module e2r_back import e2r_pkg::*; #(
  parameter int unsigned FracBits = 14
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  trig_t                  trig_i,
  output logic                   in_stall_o,
  output logic                   valid_o,
  input  logic                   stall_i,
  output logic [FracBits+1:0]    m_o [9]
);

  localparam int unsigned OutBits = FracBits + 2;

  function automatic logic [OutBits-1:0] to_out(input work_t v);
    work_t o;
    begin
      o = (v + (work_t'(1) <<< (WorkFrac - FracBits - 1))) >>> (WorkFrac - FracBits);
      if (o > (work_t'(1) <<< FracBits)) o = work_t'(1) <<< FracBits;
      if (o < -(work_t'(1) <<< FracBits)) o = -(work_t'(1) <<< FracBits);
      to_out = o[OutBits-1:0];
    end
  endfunction

  logic  en;
  logic  v1_q, v2_q, v3_q;
  trig_t t1_q;
  work_t sysx_q, sycx_q;
  work_t p_q [14];
  work_t a_q [9];

  assign en = !(valid_o && stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_q <= trig_i;
      sysx_q <= mulq(trig_i.sy, trig_i.sx);
      sycx_q <= mulq(trig_i.sy, trig_i.cx);
      p_q[0]  <= mulq(t1_q.cy, t1_q.cz);
      p_q[1]  <= mulq(sysx_q, t1_q.cz);
      p_q[2]  <= mulq(t1_q.cx, t1_q.sz);
      p_q[3]  <= mulq(sycx_q, t1_q.cz);
      p_q[4]  <= mulq(t1_q.sx, t1_q.sz);
      p_q[5]  <= mulq(t1_q.cy, t1_q.sz);
      p_q[6]  <= mulq(sysx_q, t1_q.sz);
      p_q[7]  <= mulq(t1_q.cx, t1_q.cz);
      p_q[8]  <= mulq(sycx_q, t1_q.sz);
      p_q[9]  <= mulq(t1_q.sx, t1_q.cz);
      p_q[10] <= -t1_q.sy;
      p_q[11] <= mulq(t1_q.cy, t1_q.sx);
      p_q[12] <= mulq(t1_q.cy, t1_q.cx);
      p_q[13] <= '0;
      a_q[0] <= p_q[0];
      a_q[1] <= p_q[1] - p_q[2];
      a_q[2] <= p_q[3] + p_q[4];
      a_q[3] <= p_q[5];
      a_q[4] <= p_q[6] + p_q[7];
      a_q[5] <= p_q[8] - p_q[9];
      a_q[6] <= p_q[10] + p_q[13];
      a_q[7] <= p_q[11];
      a_q[8] <= p_q[12];
    end
  end

  assign valid_o = v3_q;
  for (genvar k = 0; k < 9; k++) begin : g_out
    assign m_o[k] = to_out(a_q[k]);
  end

endmodule

[rtl/euler_to_rotation_matrix_top.sv]
// Top level of the Euler-angle (Z-Y-X) to rotation-matrix block.
//  channel | valid     | stall     | payload
//  in      | valid_i   | stall_o   | angle_x_i, angle_y_i, angle_z_i
//  out     | valid_o   | stall_i   | m00_o .. m22_o
// One beat per cycle sustained while neither side stalls; an accepted beat reaches valid_o
// through 31 CORDIC stages, the queue write and 3 product stages.
// out stall freezes the 3 product stages; a 4-deep queue fills behind them.
// The CORDIC pipelines hold while their oldest beat faces a full queue; stall_o follows.
// Reset clears all valid flags, queue pointers and the queue count; no other state.
module euler_to_rotation_matrix_top import e2r_pkg::*; #(
  parameter int unsigned ANGLE_BITS = 16,
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         stall_o,
  input  logic signed [ANGLE_BITS-1:0] angle_x_i,
  input  logic signed [ANGLE_BITS-1:0] angle_y_i,
  input  logic signed [ANGLE_BITS-1:0] angle_z_i,
  output logic                         valid_o,
  input  logic                         stall_i,
  output logic signed [FRAC_BITS+1:0]  m00_o,
  output logic signed [FRAC_BITS+1:0]  m01_o,
  output logic signed [FRAC_BITS+1:0]  m02_o,
  output logic signed [FRAC_BITS+1:0]  m10_o,
  output logic signed [FRAC_BITS+1:0]  m11_o,
  output logic signed [FRAC_BITS+1:0]  m12_o,
  output logic signed [FRAC_BITS+1:0]  m20_o,
  output logic signed [FRAC_BITS+1:0]  m21_o,
  output logic signed [FRAC_BITS+1:0]  m22_o
);

  localparam int unsigned FrontDepth = Iters + 1;
  localparam int unsigned QDepth = 4;
  localparam int unsigned Cw = $clog2(QDepth + 1);

  logic        f_valid;
  logic        f_en;
  trig_t       f_trig;
  trig_t       q_trig;
  logic        q_empty;
  logic [Cw-1:0] q_cnt;
  logic        b_stall;
  logic        pop;
  logic [FRAC_BITS+1:0] m [9];

  // front holds while its oldest beat cannot enter the queue
  assign f_en = !(f_valid && (q_cnt == Cw'(QDepth)));
  assign stall_o = !f_en;

  e2r_front #(.AngleBits(ANGLE_BITS), .Depth(FrontDepth)) u_front (
    .clk_i, .rst_ni, .en_i(f_en), .in_valid_i(valid_i && !stall_o),
    .ax_i(angle_x_i), .ay_i(angle_y_i), .az_i(angle_z_i),
    .out_valid_o(f_valid), .trig_o(f_trig));

  assign pop = !q_empty && !b_stall;

  e2r_fifo #(.Depth(QDepth)) u_fifo (
    .clk_i, .rst_ni, .push_i(f_valid && f_en), .data_i(f_trig), .pop_i(pop),
    .data_o(q_trig), .empty_o(q_empty), .count_o(q_cnt));

  e2r_back #(.FracBits(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .in_valid_i(pop), .trig_i(q_trig), .in_stall_o(b_stall),
    .valid_o, .stall_i, .m_o(m));

  assign m00_o = m[0];
  assign m01_o = m[1];
  assign m02_o = m[2];
  assign m10_o = m[3];
  assign m11_o = m[4];
  assign m12_o = m[5];
  assign m20_o = m[6];
  assign m21_o = m[7];
  assign m22_o = m[8];

endmodule

[rtl/e2r_checker.sv]
// Port-level checker for the rotation-matrix block, bound to the top level.
module e2r_checker #(
  parameter int unsigned FRAC_BITS = 14
) (
  input logic clk_i,
  input logic rst_ni,
  input logic valid_o,
  input logic stall_i,
  input logic signed [FRAC_BITS+1:0] m00_o,
  input logic signed [FRAC_BITS+1:0] m20_o,
  input logic signed [FRAC_BITS+1:0] m22_o
);

  localparam logic signed [FRAC_BITS+1:0] One = (FRAC_BITS+2)'(1) <<< FRAC_BITS;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(m00_o) && $stable(m22_o))
    else $error("stalled result changed");

  a_sat00: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (m00_o <= One) && (m00_o >= -One))
    else $error("m00 beyond full scale");

  a_sat20: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (m20_o <= One) && (m20_o >= -One))
    else $error("m20 beyond full scale");

endmodule

bind euler_to_rotation_matrix_top e2r_checker #(.FRAC_BITS(FRAC_BITS)) u_chk (
  .clk_i, .rst_ni, .valid_o, .stall_i, .m00_o, .m20_o, .m22_o);

[verif/tb_euler_to_rotation_matrix_top.sv]
// Self-checking testbench for the Euler-angle to rotation-matrix block.
module tb_euler_to_rotation_matrix_top;
  import e2r_pkg::*;

  typedef struct {
    logic signed [15:0] ax, ay, az;
  } angles_t;

  typedef struct {
    logic signed [15:0] m [9];
  } matrix_t;

  typedef struct {
    angles_t a;
    bit      known;
    matrix_t mx;
  } vector_t;

  localparam int MaxIdle = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b0;
  logic signed [15:0] angle_x_i = '0, angle_y_i = '0, angle_z_i = '0;
  logic stall_o, valid_o;
  logic signed [15:0] m00_o, m01_o, m02_o, m10_o, m11_o, m12_o, m20_o, m21_o, m22_o;

  matrix_t expected_q[$];
  angles_t beat_q[$];
  int  in_idle_pct = 0, out_stall_pct = 0;
  bit  hold_off = 1'b0;
  int  idle_cycles = 0;
  bit  failed = 1'b0;

  always #5 clk_i = ~clk_i;

  euler_to_rotation_matrix_top u_top (
    .clk_i, .rst_ni, .valid_i, .stall_o, .angle_x_i, .angle_y_i, .angle_z_i,
    .valid_o, .stall_i, .m00_o, .m01_o, .m02_o, .m10_o, .m11_o, .m12_o,
    .m20_o, .m21_o, .m22_o
  );

  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return sra(a * b + (64'sd1 <<< 29), 30);
  endfunction

  // CORDIC sine/cosine of a 16-bit binary angle, Q30.
  function automatic void trig_of(logic [15:0] raw, output longint s, output longint c);
    logic [31:0] p, t, r;
    logic [1:0]  quad;
    longint d, x, y, nx;
    p = {raw, 16'h0};
    t = p + 32'h20000000;
    quad = t[31:30];
    r = p - {quad, 30'h0};
    d = longint'(signed'(r));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      if (d >= 0) begin
        nx = x - sra(y, i);
        y = y + sra(x, i);
        d -= longint'(atan_turn(i));
      end else begin
        nx = x + sra(y, i);
        y = y - sra(x, i);
        d += longint'(atan_turn(i));
      end
      x = nx;
    end
    case (quad)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic logic signed [15:0] to_q14(longint v);
    longint o;
    o = sra(v + (64'sd1 <<< 15), 16);
    if (o > 16384) o = 16384;
    if (o < -16384) o = -16384;
    return o[15:0];
  endfunction

  function automatic matrix_t rotation_of(angles_t a);
    matrix_t r;
    longint sx, cx, sy, cy, sz, cz, sysx, sycx;
    trig_of(a.ax, sx, cx);
    trig_of(a.ay, sy, cy);
    trig_of(a.az, sz, cz);
    sysx = q30_mul(sy, sx);
    sycx = q30_mul(sy, cx);
    r.m[0] = to_q14(q30_mul(cy, cz));
    r.m[1] = to_q14(q30_mul(sysx, cz) - q30_mul(cx, sz));
    r.m[2] = to_q14(q30_mul(sycx, cz) + q30_mul(sx, sz));
    r.m[3] = to_q14(q30_mul(cy, sz));
    r.m[4] = to_q14(q30_mul(sysx, sz) + q30_mul(cx, cz));
    r.m[5] = to_q14(q30_mul(sycx, sz) - q30_mul(sx, cz));
    r.m[6] = to_q14(-sy);
    r.m[7] = to_q14(q30_mul(cy, sx));
    r.m[8] = to_q14(q30_mul(cy, cx));
    return r;
  endfunction

  function automatic matrix_t mk(int a0, a1, a2, a3, a4, a5, a6, a7, a8);
    matrix_t r;
    r.m = '{a0, a1, a2, a3, a4, a5, a6, a7, a8};
    return r;
  endfunction

  function automatic vector_t row(int x, int y, int z, bit k = 0, matrix_t mx = '{m: '{default: 0}});
    vector_t v;
    v.a = '{ax: x[15:0], ay: y[15:0], az: z[15:0]};
    v.known = k;
    v.mx = mx;
    return v;
  endfunction

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'($urandom_range(0, 7) * 16'h2000 + $urandom_range(0, 2) - 1);
      default: return 16'($urandom);
    endcase
  endfunction

  // Sender: beats wait in beat_q, predicted at acceptance.
  always @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      expected_q.push_back(rotation_of('{ax: angle_x_i, ay: angle_y_i, az: angle_z_i}));
      void'(beat_q.pop_front());
    end
    if ((!valid_i || !stall_o) || !rst_ni) begin
      if (beat_q.size() > 0 && rst_ni && $urandom_range(1, 100) > in_idle_pct) begin
        angles_t nxt;
        nxt = beat_q[0];
        valid_i   <= 1'b1;
        angle_x_i <= nxt.ax;
        angle_y_i <= nxt.ay;
        angle_z_i <= nxt.az;
      end else begin
        valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_off) stall_i <= 1'b1;
    else stall_i <= ($urandom_range(1, 100) <= out_stall_pct);
  end

  always @(posedge clk_i) begin
    matrix_t got, exp_m;
    if (rst_ni && valid_o && !stall_i) begin
      got = mk(m00_o, m01_o, m02_o, m10_o, m11_o, m12_o, m20_o, m21_o, m22_o);
      if (expected_q.size() == 0) begin
        $error("result beat with no expectation");
        failed = 1'b1;
      end else begin
        exp_m = expected_q.pop_front();
        for (int i = 0; i < 9; i++)
          if (got.m[i] !== exp_m.m[i]) begin
            $error("m%0d%0d: expected %0d, got %0d", i / 3, i % 3, exp_m.m[i], got.m[i]);
            failed = 1'b1;
          end
      end
    end
  end

  // Watchdog on cycles with no beat accepted on either side.
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i) || hold_off) idle_cycles <= 0;
    else if (beat_q.size() != 0 || expected_q.size() != 0) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= MaxIdle) begin
      $display("[euler_to_rotation_matrix_top] ERROR");
      $finish;
    end
  end

  task automatic drain();
    while (beat_q.size() != 0 || expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Directed rows; known matrices only where exact (+-1.0, 0).
  vector_t directed[] = '{
    row(0, 0, 0, 1, mk(16384, 0, 0, 0, 16384, 0, 0, 0, 16384)),
    row(-32768, -32768, -32768),
    row(32767, 32767, 32767),
    row(16384, 0, 0), row(0, 16384, 0), row(0, 0, 16384),
    row(-16384, -16384, -16384), row(8192, 8191, -8192), row(-8193, 8193, 24576),
    row(-32768, 0, 0), row(0, -32768, 0), row(0, 0, -32768),
    row(1, -1, 2), row(24575, -24576, 12345), row(16'h5555, 16'hAAAA, 16'h00FF),
    row(16'hFF00, 16'h0F0F, 16'hF0F0)
  };

  initial begin
    int phase_pct[4][2] = '{'{0, 0}, '{67, 0}, '{0, 67}, '{32, 32}};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) begin
      beat_q.push_back(directed[i].a);
    end
    drain();
    foreach (directed[i])
      if (directed[i].known && rotation_of(directed[i].a) != directed[i].mx) begin
        $error("predictor: expected fixed matrix for row %0d", i);
        failed = 1'b1;
      end
    for (int ph = 0; ph < 4; ph++) begin
      in_idle_pct = phase_pct[ph][0];
      out_stall_pct = phase_pct[ph][1];
      for (int n = 0; n < 200; n++)
        beat_q.push_back('{ax: rand_angle(), ay: rand_angle(), az: rand_angle()});
      drain();
    end
    in_idle_pct = 0;
    out_stall_pct = 0;
    for (int n = 0; n < 100; n++)
      beat_q.push_back('{ax: rand_angle(), ay: rand_angle(), az: rand_angle()});
    hold_off = 1'b1;
    repeat (200) @(posedge clk_i);
    hold_off = 1'b0;
    drain();
    repeat (50) @(posedge clk_i);
    if (!failed) $display("[euler_to_rotation_matrix_top] OK");
    else $display("[euler_to_rotation_matrix_top] ERROR");
    $finish;
  end

endmodule

[files.f]
rtl/e2r_pkg.sv
rtl/e2r_cordic.sv
rtl/e2r_front.sv
rtl/e2r_fifo.sv
rtl/e2r_back.sv
rtl/euler_to_rotation_matrix_top.sv
rtl/e2r_checker.sv
verif/tb_euler_to_rotation_matrix_top.sv
